// ===== sv/wbps_pkg.sv =====
// Package for the wildcard byte pattern scanner.
// Holds the default sizes, register index codes and port widths.
// No dependencies; every other file of the block imports it.
package wbps_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// Fixed widths of the register file and the stream words.
	localparam int SIG_BYTES   = 16;
	localparam int LEN_W       = 5;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int ADDR_W      = 64;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_LOW    = 3'd1,
		REG_PATTERN_HIGH   = 3'd2,
		REG_WILDCARD_MASK  = 3'd3,
		REG_REGION_BASE    = 3'd4
	} cfg_reg_t;

	typedef logic [SIG_BYTES-1:0][7:0] sig_bytes_t;

endpackage

// ===== sv/wbps_match.sv =====
// Masked window compare for the wildcard byte pattern scanner.
// Compares the newest bytes of the window against the signature.
// Depends on wbps_pkg.
module wbps_match #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
	input  logic [PATTERN_MAX-1:0][7:0]   window,
	input  wbps_pkg::sig_bytes_t          sig,
	input  logic [wbps_pkg::SIG_BYTES-1:0] mask,
	input  logic [wbps_pkg::LEN_W-1:0]    len,
	output logic                          hit
);
	import wbps_pkg::*;

	// Window entry of age a lines up with signature position len-1-a.
	// Positions beyond the length and wildcard positions always agree.
	always_comb begin
		logic [LEN_W-1:0] pos;
		hit = 1'b1;
		for (int a = 0; a < PATTERN_MAX; a++) begin
			pos = len - 5'd1 - LEN_W'(a);
			if (LEN_W'(a) < len && !mask[pos[3:0]]) begin
				if (window[a] != sig[pos[3:0]]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/wildcard_byte_pattern_scanner_core.sv =====
// Top level of the wildcard byte pattern scanner.
// Holds the sliding window, offset counter, config registers and output register.
// Depends on wbps_pkg and wbps_match.
//
// Usage:
//   The input stream carries one memory byte per word on s_tdata, with s_tlast
//   marking the final byte of a region. The output stream carries one 64-bit
//   match address per word: region_base plus the offset of the first byte of a
//   matching window. A word that does not complete a match gives no output.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
//   A matching byte passes through the input stage, then through the masked compare
//   and base add into the output register. Throughput is one byte per cycle while
//   the receiver does not stall, set by the single parallel compare of all window
//   positions.
//   A new byte is taken while a match waits in the output register, as long as
//   the input stage can move on; when the receiver stalls with both the input
//   stage and output register full, s_tready drops.
//   Reset clears the window, fill count, offset, valid flags and registers
//   (pattern length returns to one); the block is ready right after reset.
module wildcard_byte_pattern_scanner_core #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  logic                             s_tlast,   // last_in_region
	// Output stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [wbps_pkg::ADDR_W-1:0]      m_tdata,   // [63:0] match_address
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import wbps_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	// Configuration registers.
	logic [LEN_W-1:0]     length_q;
	logic [63:0]          pat_low_q;
	logic [63:0]          pat_high_q;
	logic [SIG_BYTES-1:0] mask_q;
	logic [ADDR_W-1:0]    base_q;

	// Scan state.
	logic [PATTERN_MAX-1:0][7:0] window_q;
	logic [FILL_W-1:0]           fill_q;
	logic [OFFSET_BITS-1:0]      offset_q;

	// Input stage.
	logic                        valid_s1;
	logic [PATTERN_MAX-1:0][7:0] win_s1;
	logic [FILL_W-1:0]           fill_s1;
	logic [OFFSET_BITS-1:0]      first_s1;

	// Output register.
	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;

	logic                        in_acc;
	logic                        out_free;
	logic [LEN_W-1:0]            eff_len;
	logic [PATTERN_MAX-1:0][7:0] shifted;
	logic [FILL_W-1:0]           fill_next;
	logic                        hit;
	sig_bytes_t                  sig;

	// Handshake: the input stage moves whenever the output register can load.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = addr_q;

	// Effective length: zero counts as one, long values clamp to the window size.
	always_comb begin
		eff_len = length_q;
		if (length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (length_q > LEN_W'(PATTERN_MAX)) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end
	end

	// Shift the new byte into the youngest slot.
	always_comb begin
		shifted[0] = s_tdata;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			shifted[k] = window_q[k-1];
		end
		fill_next = (fill_q < FILL_W'(PATTERN_MAX)) ? fill_q + FILL_W'(1) : fill_q;
	end

	assign sig = {pat_high_q, pat_low_q};

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= LEN_W'(1);
			pat_low_q  <= '0;
			pat_high_q <= '0;
			mask_q     <= '0;
			base_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: length_q   <= cfg_data[LEN_W-1:0];
				REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				REG_WILDCARD_MASK:  mask_q     <= cfg_data[SIG_BYTES-1:0];
				REG_REGION_BASE:    base_q     <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Window, fill count and offset advance on every accepted word;
	// the last byte of a region clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			offset_q <= '0;
		end else if (in_acc) begin
			if (s_tlast) begin
				window_q <= '0;
				fill_q   <= '0;
				offset_q <= '0;
			end else begin
				window_q <= shifted;
				fill_q   <= fill_next;
				offset_q <= offset_q + OFFSET_BITS'(1);
			end
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload: the shifted window as this byte sees it.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_s1   <= shifted;
			fill_s1  <= fill_next;
			first_s1 <= offset_q - OFFSET_BITS'(eff_len - LEN_W'(1));
		end
	end

	wbps_match #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_match (
		.window(win_s1),
		.sig   (sig),
		.mask  (mask_q),
		.len   (eff_len),
		.hit   (hit)
	);

	// Output register: only matching windows that hold at least the pattern length produce a word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && hit && (LEN_W'(fill_s1) >= eff_len);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			addr_q <= base_q + ADDR_W'(first_s1);
		end
	end

endmodule

// ===== sv/wbps_checker.sv =====
// Port-level checker for the wildcard byte pattern scanner.
// Watches the stream handshakes of the top level; bound to it below.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner_core.
module wbps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [wbps_pkg::ADDR_W-1:0] m_tdata
);
	import wbps_pkg::*;

	// A stalled output word stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// A stalled output word keeps its address.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output address changed while stalled");

	// The input side only backs up when the output side is stalled.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input not ready without an output stall");

	// A fresh match appears only after an input word was taken and passed through the input stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without an input word two cycles earlier");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== sim/tb_wildcard_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_scanner_core.
// Streams bytes with random gaps and output stalls and checks every match address
// against an internal scan model. Depends on wbps_pkg and the scanner RTL.
module tb_wildcard_byte_pattern_scanner_core;
	import wbps_pkg::*;

	localparam int WIN_DEPTH    = PATTERN_MAX_DEF;
	localparam int OFFS_W       = OFFSET_BITS_DEF;
	localparam int NUM_CFG_REGS = REG_REGION_BASE + 1;
	localparam int PHASES       = 12;
	localparam int PHASE_BYTES  = 145;
	localparam int SETTLE       = 4;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int MAX_REPORTS  = 10;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [ADDR_W-1:0]      m_tdata;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Scan model state and its copy of the registers.
	logic [7:0]        win_bytes [WIN_DEPTH];
	int unsigned       win_fill;
	logic [OFFS_W-1:0] byte_offs;
	logic [LEN_W-1:0]  sig_len;
	logic [63:0]       sig_low;
	logic [63:0]       sig_high;
	logic [15:0]       wild_bits;
	logic [63:0]       base_addr;

	logic [ADDR_W-1:0] expected_addrs [$];
	int                fail_count;
	int                burst_left;
	int                rx_left;
	int                rx_mode;

	wildcard_byte_pattern_scanner_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Signature byte at a position, taken from the two pattern registers.
	function automatic logic [7:0] sig_byte_at(input int pos);
		if (pos < 8)
			return sig_low[8*pos +: 8];
		return sig_high[8*(pos-8) +: 8];
	endfunction

	// Length in use: zero counts as one, anything past the window as the window.
	function automatic int unsigned active_len();
		int unsigned n;
		n = {27'd0, sig_len};
		if (n == 0)
			n = 1;
		if (n > WIN_DEPTH)
			n = WIN_DEPTH;
		return n;
	endfunction

	// Shift one byte into the window and queue the match address it produces, if any.
	task automatic scan_byte(input logic [7:0] d, input logic is_last);
		int unsigned       n;
		bit                hit;
		logic [OFFS_W-1:0] first_offs;
		n = active_len();
		for (int k = WIN_DEPTH - 1; k > 0; k--)
			win_bytes[k] = win_bytes[k-1];
		win_bytes[0] = d;
		if (win_fill < WIN_DEPTH)
			win_fill++;
		if (win_fill >= n) begin
			hit = 1'b1;
			for (int i = 0; i < n; i++)
				if (!wild_bits[i] && win_bytes[n-1-i] != sig_byte_at(i))
					hit = 1'b0;
			if (hit) begin
				first_offs = byte_offs - OFFS_W'(n - 1);
				expected_addrs = {expected_addrs, base_addr + ADDR_W'(first_offs)};
			end
		end
		byte_offs = byte_offs + 1'b1;
		if (is_last) begin
			foreach (win_bytes[k])
				win_bytes[k] = 8'h00;
			win_fill = 0;
			byte_offs = '0;
		end
	endtask

	// Register write; the model copy follows at once since the block is idle.
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_PATTERN_LENGTH: sig_len   = value[LEN_W-1:0];
			REG_PATTERN_LOW:    sig_low   = value;
			REG_PATTERN_HIGH:   sig_high  = value;
			REG_WILDCARD_MASK:  wild_bits = value[15:0];
			REG_REGION_BASE:    base_addr = value;
			default: ;
		endcase
	endtask

	task automatic cfg_end();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Send one word; the sender runs in bursts with random gaps between them.
	task automatic send_word(input logic [7:0] d, input logic is_last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scan_byte(d, is_last);
	endtask

	// Stop sending, let every expected match arrive and the pipeline empty.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_addrs.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic note_failure(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// Output receiver: ready pattern switches between always, half, rare and alternating.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(8, 80);
		end
		rx_left--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 9) < 2);
			default: m_tready <= ~m_tready;
		endcase
	end

	// Compare each accepted match word with the oldest expected address.
	always @(posedge clk) begin
		logic [ADDR_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_addrs.size() == 0) begin
				note_failure($sformatf("unexpected match word %h", m_tdata));
			end else begin
				want = expected_addrs.pop_front();
				if (m_tdata !== want)
					note_failure($sformatf("match_address expected %h got %h", want, m_tdata));
			end
		end
	end

	// After reset: length one, signature all zero, so a zero byte matches.
	task automatic test_reset_defaults();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
	endtask

	// Length zero counts as one; upper data bits of the write are dropped.
	task automatic test_length_zero();
		wait_idle();
		cfg_write(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FF80);
		cfg_write(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
		cfg_end();
		send_word(8'h80, 1'b1);
	endtask

	// Length 31 saturates at the window size; the base add wraps past the top.
	task automatic test_length_saturation();
		wait_idle();
		cfg_write(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_write(REG_PATTERN_LOW, '1);
		cfg_write(REG_PATTERN_HIGH, '1);
		cfg_write(REG_WILDCARD_MASK, 64'hFFFF_FFFF_FFFF_0001);
		cfg_write(REG_REGION_BASE, '1);
		cfg_end();
		send_word(8'h00, 1'b0);
		repeat (15) send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	// Signature bytes and wildcard bits beyond the length must not matter.
	task automatic test_unused_positions();
		logic [63:0] junk;
		wait_idle();
		junk = {$urandom, $urandom};
		junk[15:0] = 16'h1234;
		cfg_write(REG_PATTERN_LOW, junk);
		cfg_write(REG_PATTERN_HIGH, {$urandom, $urandom});
		junk = {$urandom, $urandom};
		junk[1:0] = 2'b00;
		cfg_write(REG_WILDCARD_MASK, junk);
		cfg_write(REG_PATTERN_LENGTH, 64'hA5A5_0000_0000_0022);
		cfg_write(REG_REGION_BASE, 64'h0000_0000_0000_1000);
		cfg_end();
		send_word(8'h34, 1'b0);
		send_word(8'h12, 1'b1);
	endtask

	// Writes to indexes past the register file leave everything as it was.
	task automatic test_bad_index();
		wait_idle();
		for (int idx = NUM_CFG_REGS; idx < (1 << CFG_INDEX_W); idx++)
			cfg_write(idx[CFG_INDEX_W-1:0], {$urandom, $urandom});
		cfg_end();
		send_word(8'h34, 1'b0);
		send_word(8'h12, 1'b1);
	endtask

	// A longer length set mid-region matches on bytes already in the window.
	task automatic test_length_change_in_region();
		wait_idle();
		cfg_write(REG_PATTERN_LENGTH, 64'd1);
		cfg_end();
		send_word(8'h34, 1'b0);
		wait_idle();
		cfg_write(REG_PATTERN_LENGTH, 64'd2);
		cfg_end();
		send_word(8'h12, 1'b1);
	endtask

	// Random phases: mostly embedded signatures, some broken ones, some noise.
	task automatic test_random_scan();
		int          sent;
		int          n;
		int          cnt;
		int          bad_pos;
		bit          broken;
		logic [7:0]  b;
		logic [63:0] v;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			v = {$urandom, $urandom};
			case (phase)
				0: v[4:0] = 5'd16;
				1: v[4:0] = 5'd0;
				2: v[4:0] = 5'd31;
				3: v[4:0] = 5'd1;
				default: begin
					cnt = $urandom_range(0, 19);
					if (cnt < 14)
						v[4:0] = 5'($urandom_range(1, 6));
					else if (cnt < 17)
						v[4:0] = 5'($urandom_range(7, 16));
					else
						v[4:0] = 5'($urandom_range(17, 31));
				end
			endcase
			cfg_write(REG_PATTERN_LENGTH, v);
			cfg_write(REG_PATTERN_LOW, (phase == 4) ? 64'd0 : (phase == 5) ? '1 :
				{$urandom, $urandom});
			cfg_write(REG_PATTERN_HIGH, (phase == 4) ? 64'd0 : (phase == 5) ? '1 :
				{$urandom, $urandom});
			v = {$urandom, $urandom};
			if (phase == 6)
				v[15:0] = 16'hFFFF;
			else if (phase == 7)
				v[15:0] = 16'h0000;
			else
				v[15:0] = 16'($urandom & $urandom);
			cfg_write(REG_WILDCARD_MASK, v);
			cfg_write(REG_REGION_BASE, (phase == 8) ? 64'd0 : (phase == 9) ? '1 :
				(phase == 10) ? 64'hFFFF_FFFF_FFFF_FF00 : {$urandom, $urandom});
			cfg_end();

			sent = 0;
			while (sent < PHASE_BYTES) begin
				if ($urandom_range(0, 9) < 6) begin
					// One copy of the signature, wildcard positions random.
					n = active_len();
					broken = ($urandom_range(0, 7) == 0);
					bad_pos = $urandom_range(0, n - 1);
					for (int i = 0; i < n; i++) begin
						b = wild_bits[i] ? 8'($urandom) : sig_byte_at(i);
						if (broken && i == bad_pos)
							b = b ^ (8'h01 << $urandom_range(0, 7));
						send_word(b, (i == n - 1) ? ($urandom_range(0, 7) == 0) :
							($urandom_range(0, 63) == 0));
						sent++;
					end
				end else begin
					// Noise, partly made of signature bytes to build near misses.
					cnt = $urandom_range(1, 6);
					for (int i = 0; i < cnt; i++) begin
						b = $urandom_range(0, 1) ? 8'($urandom) :
							sig_byte_at($urandom_range(0, WIN_DEPTH - 1));
						send_word(b, $urandom_range(0, 39) == 0);
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		int waited;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		s_tlast    = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		fail_count = 0;
		burst_left = 0;
		rx_left    = 0;
		rx_mode    = 0;
		foreach (win_bytes[k])
			win_bytes[k] = 8'h00;
		win_fill  = 0;
		byte_offs = '0;
		sig_len   = 5'd1;
		sig_low   = '0;
		sig_high  = '0;
		wild_bits = '0;
		base_addr = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_length_zero();
		test_length_saturation();
		test_unused_positions();
		test_bad_index();
		test_length_change_in_region();
		test_random_scan();

		// Drain the remaining matches, bounded, then let the pipeline settle.
		@(negedge clk);
		s_tvalid <= 1'b0;
		for (waited = 0; expected_addrs.size() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
		if (expected_addrs.size() != 0)
			note_failure($sformatf("%0d expected match words never arrived",
				expected_addrs.size()));
		repeat (2 * SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/wbps_pkg.sv
sv/wbps_match.sv
sv/wildcard_byte_pattern_scanner_core.sv
sv/wbps_checker.sv
sim/tb_wildcard_byte_pattern_scanner_core.sv
